[rtl/sadp_pkg.sv]
// Package for store address and data prep: opcode, extend, byte enable and status codes.
// No dependencies; imported by store_address_and_data_prep.
package sadp_pkg;

  // Store opcodes
  localparam logic [3:0] OP_STRB  = 4'd0;
  localparam logic [3:0] OP_STRH  = 4'd1;
  localparam logic [3:0] OP_STRW  = 4'd2;
  localparam logic [3:0] OP_STR   = 4'd3;
  localparam logic [3:0] OP_STREX = 4'd7;
  localparam logic [3:0] OP_VSTRB = 4'd8;
  localparam logic [3:0] OP_VSTRH = 4'd9;
  localparam logic [3:0] OP_VSTRS = 4'd10;
  localparam logic [3:0] OP_VSTRD = 4'd11;
  localparam logic [3:0] OP_VSTRQ = 4'd12;

  // Offset extend codes
  localparam logic [3:0] EXT_UXTB = 4'd8;
  localparam logic [3:0] EXT_UXTH = 4'd9;
  localparam logic [3:0] EXT_UXTW = 4'd10;
  localparam logic [3:0] EXT_UXTX = 4'd11;
  localparam logic [3:0] EXT_SXTB = 4'd12;
  localparam logic [3:0] EXT_SXTH = 4'd13;
  localparam logic [3:0] EXT_SXTW = 4'd14;
  localparam logic [3:0] EXT_SXTX = 4'd15;

  // Byte enable masks
  localparam logic [15:0] BE_BYTE = 16'h0001;
  localparam logic [15:0] BE_HALF = 16'h0003;
  localparam logic [15:0] BE_WORD = 16'h000f;
  localparam logic [15:0] BE_DBL  = 16'h00ff;
  localparam logic [15:0] BE_QUAD = 16'hffff;
  localparam logic [15:0] BE_NONE = 16'h0000;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_EXCL_WAIT = 2'd1,
    ST_BAD_OPC  = 2'd2
  } status_e;

endpackage

[rtl/store_address_and_data_prep.sv]
// Store address and data prep: offset extend/shift, address adders, lane align,
// byte enables and status. Depends on sadp_pkg.
//
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+--------------------------------
// command   | in        | start_i, busy_o           | base, offset, shift, data, ctrl
// result    | out       | result_valid_o (strobe)   | addr, new base, data, be, status
//
// Throughput: one transaction per cycle; busy_o never rises.
// Path: accept loads the input register, then the result register; one pass of
//   extend/shift/add logic lies in between.
// Reset clears only the two valid flags; payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module store_address_and_data_prep (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [31:0]            base_value_i,
  input  logic [63:0]            offset_value_i,
  input  logic [5:0]             shift_amount_i,
  input  logic [63:0]            data_low_i,
  input  logic [63:0]            data_high_i,
  input  logic [3:0]             store_opcode_i,
  input  logic [3:0]             extend_op_i,
  input  logic [1:0]             addr_mode_i,
  input  logic                   writeback_i,
  input  logic                   partial_lane_i,
  input  logic [3:0]             lane_index_i,
  input  logic                   exclusive_class_i,
  output logic                   result_valid_o,
  output logic [31:0]            store_addr_o,
  output logic [31:0]            new_base_o,
  output logic                   base_update_o,
  output logic [63:0]            out_data_low_o,
  output logic [63:0]            out_data_high_o,
  output logic [15:0]            byte_enable_o,
  output sadp_pkg::status_e      status_o
);
  import sadp_pkg::*;

  // Input register
  logic        in_valid_q;
  logic [31:0] base_q;
  logic [63:0] offset_q;
  logic [5:0]  shift_q;
  logic [63:0] dlo_q;
  logic [63:0] dhi_q;
  logic [3:0]  opc_q;
  logic [3:0]  ext_q;
  logic [1:0]  mode_q;
  logic        wb_q;
  logic        part_q;
  logic [3:0]  lane_q;
  logic        excl_q;

  // Result register
  logic        out_valid_q;
  logic [31:0] addr_q,   addr_d;
  logic [31:0] nbase_q,  nbase_d;
  logic        bupd_q,   bupd_d;
  logic [63:0] odlo_q,   odlo_d;
  logic [63:0] odhi_q;
  logic [15:0] be_q,     be_d;
  status_e     status_q, status_d;

  logic        accept;
  logic [31:0] ext32;
  logic        do_shift;
  logic [31:0] off_shifted;
  logic [31:0] off32;
  logic        bad;
  logic        is_vlane;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      base_q   <= base_value_i;
      offset_q <= offset_value_i;
      shift_q  <= shift_amount_i;
      dlo_q    <= data_low_i;
      dhi_q    <= data_high_i;
      opc_q    <= store_opcode_i;
      ext_q    <= extend_op_i;
      mode_q   <= addr_mode_i;
      wb_q     <= writeback_i;
      part_q   <= partial_lane_i;
      lane_q   <= lane_index_i;
      excl_q   <= exclusive_class_i;
    end
  end

  // Offset extend; only the low 32 bits ever reach the adders.
  always_comb begin
    do_shift = 1'b1;
    unique case (ext_q) inside
      EXT_UXTB:                     ext32 = {24'd0, offset_q[7:0]};
      EXT_UXTH:                     ext32 = {16'd0, offset_q[15:0]};
      EXT_SXTB:                     ext32 = {{24{offset_q[7]}}, offset_q[7:0]};
      EXT_SXTH:                     ext32 = {{16{offset_q[15]}}, offset_q[15:0]};
      EXT_UXTW, EXT_UXTX,
      EXT_SXTW, EXT_SXTX:           ext32 = offset_q[31:0];
      default: begin
        // no extend or undefined code: offset passes through unshifted
        ext32    = offset_q[31:0];
        do_shift = 1'b0;
      end
    endcase
  end

  // Shift of 32 or more clears the low word.
  assign off_shifted = do_shift ? (ext32 << shift_q) : ext32;
  assign off32       = mode_q[1] ? off_shifted : (32'd0 - off_shifted);
  assign nbase_d     = base_q + off32;
  assign addr_d      = mode_q[0] ? nbase_d : base_q;

  // Lane align for single-lane vector stores
  assign is_vlane = part_q && (opc_q == OP_VSTRB || opc_q == OP_VSTRH ||
                               opc_q == OP_VSTRS || opc_q == OP_VSTRD);
  always_comb begin
    if (!is_vlane) begin
      odlo_d = dlo_q;
    end else if (lane_q[3]) begin
      odlo_d = dhi_q >> {lane_q[2:0], 3'b000};
    end else begin
      odlo_d = dlo_q >> {lane_q[2:0], 3'b000};
    end
  end

  // Byte enables by opcode
  always_comb begin
    bad = 1'b0;
    unique case (opc_q) inside
      OP_STRB, OP_VSTRB:           be_d = BE_BYTE;
      OP_STRH, OP_VSTRH:           be_d = BE_HALF;
      OP_STRW, OP_STREX, OP_VSTRS: be_d = BE_WORD;
      OP_STR, OP_VSTRD:            be_d = BE_DBL;
      OP_VSTRQ:                    be_d = BE_QUAD;
      default: begin
        be_d = BE_NONE;
        bad  = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (bad) begin
      status_d = ST_BAD_OPC;
    end else if (excl_q && opc_q == OP_STREX) begin
      status_d = ST_EXCL_WAIT;
    end else begin
      status_d = ST_COMPLETE;
    end
  end

  assign bupd_d = wb_q && !bad;

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      addr_q   <= addr_d;
      nbase_q  <= nbase_d;
      bupd_q   <= bupd_d;
      odlo_q   <= odlo_d;
      odhi_q   <= dhi_q;
      be_q     <= be_d;
      status_q <= status_d;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign store_addr_o    = addr_q;
  assign new_base_o      = nbase_q;
  assign base_update_o   = bupd_q;
  assign out_data_low_o  = odlo_q;
  assign out_data_high_o = odhi_q;
  assign byte_enable_o   = be_q;
  assign status_o        = status_q;

  // Every accepted transaction shows up after the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 result_valid_o)
    else $error("accepted transaction produced no result");

  // No strobe unless the input register held an accepted transaction.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(in_valid_q))
    else $error("result strobe without accepted transaction");

  // Bad opcode: no byte enables and no base writeback.
  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_BAD_OPC) |-> (byte_enable_o == BE_NONE && !base_update_o))
    else $error("bad opcode leaked enables or writeback");

  // Exclusive wait only for a word store.
  a_excl_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_EXCL_WAIT) |-> byte_enable_o == BE_WORD)
    else $error("exclusive wait with wrong byte enables");

endmodule
